@@ rtl/trs_pkg.sv @@
`default_nettype none

package trs_pkg;

	// CORDIC depth, limited to the length of the arctangent table
	localparam int ROTATION_STAGES = 16;
	localparam int TABLE_LEN       = 24;
	localparam int CORDIC_STAGES   = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;
	localparam int STAGE_W         = $clog2(TABLE_LEN);

	// APB register map, one 32-bit word per register
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_OFFSET_X = 3'd0,
		REG_OFFSET_Y = 3'd1,
		REG_ROTATION = 3'd2,
		REG_SCALE_X  = 3'd3,
		REG_SCALE_Y  = 3'd4
	} reg_idx_t;

	localparam logic [31:0]        SCALE_ONE   = 32'h0001_0000;
	localparam logic [15:0]        ANGLE_BIAS  = 16'h2000;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
	localparam logic signed [31:0] NEG_ONE_Q30 = -32'sh4000_0000;
	localparam logic signed [63:0] ROUND_ROT   = 64'sd536870912;
	localparam logic signed [63:0] ROUND_SCALE = 64'sd32768;
	localparam logic signed [63:0] SAT_MAX     = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_MIN     = 64'shFFFF_FFFF_8000_0000;

	// One CORDIC cell's worth of state, plus the point riding alongside
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] z;
		logic [1:0]         quad;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               ovf;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               ovf;
	} res_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// Arctangent of 2^-i in units of 2^-32 turn
	function automatic logic signed [31:0] atan_turn(input logic [STAGE_W-1:0] idx);
		logic signed [31:0] t;
		case (idx)
			5'd0:    t = 32'sh2000_0000;
			5'd1:    t = 32'sh12E4_051E;
			5'd2:    t = 32'sh09FB_385B;
			5'd3:    t = 32'sh0511_11D4;
			5'd4:    t = 32'sh028B_0D43;
			5'd5:    t = 32'sh0145_D7E1;
			5'd6:    t = 32'sh00A2_F61E;
			5'd7:    t = 32'sh0051_7C55;
			5'd8:    t = 32'sh0028_BE53;
			5'd9:    t = 32'sh0014_5F2F;
			5'd10:   t = 32'sh000A_2F98;
			5'd11:   t = 32'sh0005_17CC;
			5'd12:   t = 32'sh0002_8BE6;
			5'd13:   t = 32'sh0001_45F3;
			5'd14:   t = 32'sh0000_A2F9;
			5'd15:   t = 32'sh0000_517C;
			5'd16:   t = 32'sh0000_28BE;
			5'd17:   t = 32'sh0000_145F;
			5'd18:   t = 32'sh0000_0A2F;
			5'd19:   t = 32'sh0000_0517;
			5'd20:   t = 32'sh0000_028B;
			5'd21:   t = 32'sh0000_0145;
			5'd22:   t = 32'sh0000_00A2;
			5'd23:   t = 32'sh0000_0051;
			default: t = 32'sh0000_0000;
		endcase
		return t;
	endfunction

	// Clamp a wide signed value to 32 bits and flag the clamp
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.ovf = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r.ovf = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.ovf = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/trs_if.sv @@
`default_nettype none

// Point channel into the block
interface trs_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;

	modport source(output valid, output point_x, output point_y, input ready);
	modport sink(input valid, input point_x, input point_y, output ready);
endinterface

// Result channel out of the block
interface trs_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;
	logic               overflow;

	modport source(output valid, output result_x, output result_y, output overflow, input ready);
	modport sink(input valid, input result_x, input result_y, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/trs_cell.sv @@
`default_nettype none

module trs_cell import trs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [STAGE_W-1:0] stage,
	input  wire logic               in_valid,
	input  wire cell_t              in_data,
	output logic                    out_valid,
	output cell_t                   out_data
);

	logic signed [31:0] x, y, z, dx, dy, t;
	cell_t              nxt;

	// One micro-rotation: steer towards zero residual angle
	always_comb begin
		x   = in_data.cx;
		y   = in_data.cy;
		z   = in_data.z;
		dx  = x >>> stage;
		dy  = y >>> stage;
		t   = atan_turn(stage);
		nxt = in_data;
		if (!z[31]) begin
			nxt.cx = x - dy;
			nxt.cy = y + dx;
			nxt.z  = z - t;
		end else begin
			nxt.cx = x + dy;
			nxt.cy = y - dx;
			nxt.z  = z + t;
		end
	end

	// Advance the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	// Hand the cell state to the neighbour
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out_data <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ rtl/trs_rotate.sv @@
`default_nettype none

module trs_rotate import trs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire cell_t in_data,
	output logic       out_valid,
	output res_t       out_data
);

	logic signed [31:0] c_raw, s_raw, c_cl, s_cl, cosv, sinv, px, py;
	logic signed [63:0] p_xc_s1, p_ys_s1, p_xs_s1, p_yc_s1;
	logic               ovf_s1, vld_s1;
	logic signed [63:0] sum_x, sum_y;
	sat_t               sat_x, sat_y;

	// Clamp CORDIC output to unit range and fold in the quadrant
	always_comb begin
		c_raw = in_data.cx;
		s_raw = in_data.cy;
		px    = in_data.px;
		py    = in_data.py;
		c_cl  = (c_raw > ONE_Q30) ? ONE_Q30 : ((c_raw < NEG_ONE_Q30) ? NEG_ONE_Q30 : c_raw);
		s_cl  = (s_raw > ONE_Q30) ? ONE_Q30 : ((s_raw < NEG_ONE_Q30) ? NEG_ONE_Q30 : s_raw);
		case (in_data.quad)
			2'd0: begin
				cosv = c_cl;
				sinv = s_cl;
			end
			2'd1: begin
				cosv = -s_cl;
				sinv = c_cl;
			end
			2'd2: begin
				cosv = -c_cl;
				sinv = -s_cl;
			end
			default: begin
				cosv = s_cl;
				sinv = -c_cl;
			end
		endcase
	end

	// Stage 1: form the four products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			p_xc_s1 <= px * cosv;
			p_ys_s1 <= py * sinv;
			p_xs_s1 <= px * sinv;
			p_yc_s1 <= py * cosv;
			ovf_s1  <= in_data.ovf;
		end
	end

	// Stage 2: combine, round to Q16.16 and clamp
	always_comb begin
		sum_x = p_xc_s1 - p_ys_s1 + ROUND_ROT;
		sum_y = p_xs_s1 + p_yc_s1 + ROUND_ROT;
		sat_x = sat32(sum_x >>> 30);
		sat_y = sat32(sum_y >>> 30);
	end

	always_ff @(posedge clk) begin
		if (en && vld_s1) begin
			out_data.x   <= sat_x.val;
			out_data.y   <= sat_y.val;
			out_data.ovf <= ovf_s1 | sat_x.ovf | sat_y.ovf;
		end
	end

endmodule

`default_nettype wire

@@ rtl/trs_scale.sv @@
`default_nettype none

module trs_scale import trs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic signed [31:0] scale_x,
	input  wire logic signed [31:0] scale_y,
	input  wire logic               in_valid,
	input  wire res_t               in_data,
	output logic                    out_valid,
	output res_t                    out_data
);

	logic signed [31:0] rx, ry;
	logic signed [63:0] p_x_s1, p_y_s1;
	logic               ovf_s1, vld_s1;
	logic signed [63:0] sum_x, sum_y;
	sat_t               sat_x, sat_y;

	always_comb begin
		rx = in_data.x;
		ry = in_data.y;
	end

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	// Stage 1: per-axis scale products
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			p_x_s1 <= rx * scale_x;
			p_y_s1 <= ry * scale_y;
			ovf_s1 <= in_data.ovf;
		end
	end

	// Stage 2: round back to Q16.16 and clamp
	always_comb begin
		sum_x = p_x_s1 + ROUND_SCALE;
		sum_y = p_y_s1 + ROUND_SCALE;
		sat_x = sat32(sum_x >>> 16);
		sat_y = sat32(sum_y >>> 16);
	end

	always_ff @(posedge clk) begin
		if (en && vld_s1) begin
			out_data.x   <= sat_x.val;
			out_data.y   <= sat_y.val;
			out_data.ovf <= ovf_s1 | sat_x.ovf | sat_y.ovf;
		end
	end

endmodule

`default_nettype wire

@@ rtl/translate_rotate_scale_2d.sv @@
// translate_rotate_scale_2d
//
// Transforms one Q16.16 point per transaction: translate by the offset,
// rotate about the origin by the configured angle, scale each axis.
// Points arrive on the point channel and leave on the result channel, both
// valid/ready; a transaction moves when valid and ready are high at a clock
// edge. Every point gives exactly one result, in order, with overflow set
// if any intermediate or final coordinate was clamped to 32 bits.
// From acceptance to result valid a point passes the translation register,
// which loads at the accepting edge, then each CORDIC cell, two rotation
// stages, two scale stages and the output register.
// Throughput is one point per cycle while the skid register is empty; each
// CORDIC cell carries the angle residue and the point along with it.
// A skid register behind the output register absorbs one more result when
// the receiver stalls; the whole pipeline then holds and point.ready drops
// until the skid register drains.
// Reset clears all valid flags and loads the registers with their defaults
// (offsets 0, angle 0, scales 1.0). Registers sit on the APB port at byte
// address 4*index; write them only while no transaction is in flight.

`default_nettype none

module translate_rotate_scale_2d import trs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	trs_point_if.sink              point,
	trs_result_if.source           result
);

	logic signed [31:0] offset_x_q, offset_y_q, scale_x_q, scale_y_q;
	logic [15:0]        angle_q;
	reg_idx_t           reg_idx;
	logic               wr_en;

	logic               en;
	logic [15:0]        angle_b;
	logic signed [63:0] sum_x, sum_y;
	sat_t               tr_x, tr_y;
	cell_t              front;

	logic               cell_v [0:CORDIC_STAGES];
	cell_t              cell_d [0:CORDIC_STAGES];

	logic               rot_v, scl_v;
	res_t               rot_d, scl_d;

	logic               out_vld_q, skid_vld_q;
	res_t               out_q, skid_q;
	logic               take, arrive;

	// Register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
			angle_q    <= '0;
			scale_x_q  <= SCALE_ONE;
			scale_y_q  <= SCALE_ONE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OFFSET_X: offset_x_q <= pwdata;
				REG_OFFSET_Y: offset_y_q <= pwdata;
				REG_ROTATION: angle_q    <= pwdata[15:0];
				REG_SCALE_X:  scale_x_q  <= pwdata;
				REG_SCALE_Y:  scale_y_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OFFSET_X: prdata = offset_x_q;
			REG_OFFSET_Y: prdata = offset_y_q;
			REG_ROTATION: prdata = {16'h0000, angle_q};
			REG_SCALE_X:  prdata = scale_x_q;
			REG_SCALE_Y:  prdata = scale_y_q;
			default:      prdata = '0;
		endcase
	end

	// Pipeline advances whenever the skid register is free
	assign en          = !skid_vld_q;
	assign point.ready = en;

	// Translate, split the angle into quadrant and residue, seed the CORDIC
	always_comb begin
		sum_x         = 64'(point.point_x) + 64'(offset_x_q);
		sum_y         = 64'(point.point_y) + 64'(offset_y_q);
		tr_x          = sat32(sum_x);
		tr_y          = sat32(sum_y);
		angle_b       = angle_q + ANGLE_BIAS;
		front.cx      = CORDIC_GAIN;
		front.cy      = '0;
		front.z       = {{3{~angle_b[13]}}, angle_b[12:0], 16'h0000};
		front.quad    = angle_b[15:14];
		front.px      = tr_x.val;
		front.py      = tr_y.val;
		front.ovf     = tr_x.ovf | tr_y.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_v[0] <= 1'b0;
		end else if (en) begin
			cell_v[0] <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && point.valid) begin
			cell_d[0] <= front;
		end
	end

	// Chain of CORDIC cells
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		trs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.stage    (STAGE_W'(i)),
			.in_valid (cell_v[i]),
			.in_data  (cell_d[i]),
			.out_valid(cell_v[i+1]),
			.out_data (cell_d[i+1])
		);
	end

	trs_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cell_v[CORDIC_STAGES]),
		.in_data  (cell_d[CORDIC_STAGES]),
		.out_valid(rot_v),
		.out_data (rot_d)
	);

	trs_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.scale_x  (scale_x_q),
		.scale_y  (scale_y_q),
		.in_valid (rot_v),
		.in_data  (rot_d),
		.out_valid(scl_v),
		.out_data (scl_d)
	);

	// Output register with skid stage
	assign take   = out_vld_q && result.ready;
	assign arrive = en && scl_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= arrive;
			end
		end else if (arrive) begin
			if (!out_vld_q) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && skid_vld_q) begin
			out_q <= skid_q;
		end else if (arrive && (take || !out_vld_q)) begin
			out_q <= scl_d;
		end
		if (arrive && out_vld_q && !take) begin
			skid_q <= scl_d;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.result_x = out_q.x;
	assign result.result_y = out_q.y;
	assign result.overflow = out_q.ovf;

endmodule

`default_nettype wire

@@ tb/translate_rotate_scale_2d_tb.sv @@
`timescale 1ns / 1ps

module translate_rotate_scale_2d_tb;
	import trs_pkg::*;

	localparam int          RESET_CYCLES     = 11;
	localparam int          RANDOM_PHASES    = 14;
	localparam int          POINTS_PER_PHASE = 125;
	localparam int unsigned CYCLE_LIMIT      = 400000;
	localparam int          PRINT_LIMIT      = 40;
	localparam int          SETTLE_CYCLES    = CORDIC_STAGES + 26;
	localparam int          DIRECTED_ROWS    = 39;

	localparam logic [31:0] MAX_Q16     = 32'h7FFF_FFFF;
	localparam logic [31:0] MIN_Q16     = 32'h8000_0000;
	localparam logic [31:0] MINUS_ONE   = 32'hFFFF_0000;
	localparam longint      WORD_MAX    = 64'sd2147483647;
	localparam longint      WORD_MIN    = -64'sd2147483648;
	localparam longint      UNIT_Q30    = 64'sd1073741824;
	localparam longint      HALF_Q30    = 64'sd536870912;
	localparam longint      HALF_Q16    = 64'sd32768;

	// arctangent of 2^-i in units of 2^-32 turn
	localparam logic signed [31:0] ATAN_TURNS [TABLE_LEN] = '{
		32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
		32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
		32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
		32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2F9, 32'sh0000_517C,
		32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A2F, 32'sh0000_0517,
		32'sh0000_028B, 32'sh0000_0145, 32'sh0000_00A2, 32'sh0000_0051
	};

	typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;
	typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               ovf;
	} xy_result_t;

	// a: register value or point x, b: point y
	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [31:0] a;
		logic [31:0] b;
		logic        typed;
		xy_result_t  want;
	} stim_row_t;

	localparam xy_result_t NO_RESULT = '0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_POINT, REG_OFFSET_X, 32'h0, 32'h0, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
		'{ROW_POINT, REG_OFFSET_X, 32'h1, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MAX_Q16, MAX_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MIN_Q16, MIN_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MAX_Q16, MIN_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_OFFSET_X, MAX_Q16, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_OFFSET_Y, MIN_Q16, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MAX_Q16, MIN_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MIN_Q16, MAX_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_X, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_Y, 32'h0, 32'h0, 1'b0, NO_RESULT},
		// x clamps on translation, zero scale flattens the rest
		'{ROW_POINT, REG_OFFSET_X, MAX_Q16, 32'h0, 1'b1, '{32'sh0, 32'sh0, 1'b1}},
		'{ROW_POINT, REG_OFFSET_X, MIN_Q16, MAX_Q16, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
		'{ROW_WRITE, REG_OFFSET_X, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_OFFSET_Y, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ROTATION, 32'h0000_4000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_X, MAX_Q16, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_Y, MIN_Q16, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h0001_0000, 32'h0002_0000, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MAX_Q16, MIN_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MINUS_ONE, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ROTATION, 32'h0000_2000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_X, SCALE_ONE, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_Y, MINUS_ONE, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MAX_Q16, MAX_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MIN_Q16, MAX_Q16, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h0001_0000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ROTATION, 32'h0000_8000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h0003_0000, 32'hFFFE_0000, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, MIN_Q16, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ROTATION, 32'h0000_C000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h0001_0000, 32'h0001_0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ROTATION, 32'h0000_FFFF, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'h7FFF_0000, 32'h1234_5678, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ROTATION, 32'h0000_6000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SCALE_X, 32'h0000_8000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_OFFSET_X, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, NO_RESULT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	trs_point_if  pt_if();
	trs_result_if res_if();

	// register copies used for prediction
	longint      cfg_offset_x = 0;
	longint      cfg_offset_y = 0;
	logic [15:0] cfg_angle    = '0;
	longint      cfg_scale_x  = longint'(SCALE_ONE);
	longint      cfg_scale_y  = longint'(SCALE_ONE);

	xy_result_t  awaited_results [$];
	xy_result_t  head_result;
	int          burst_left = 0;
	bit          point_driven = 1'b0;
	int unsigned cycle_count = 0;
	int          mismatches = 0;
	int          points_sent = 0;
	int          results_checked = 0;
	int          overflow_seen = 0;
	int          register_writes = 0;

	translate_rotate_scale_2d DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.point(pt_if),
		.result(res_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic longint clamp32(input longint v, inout bit ovf);
		if (v > WORD_MAX) begin
			ovf = 1'b1;
			return WORD_MAX;
		end
		if (v < WORD_MIN) begin
			ovf = 1'b1;
			return WORD_MIN;
		end
		return v;
	endfunction

	// translate, rotate by CORDIC sine and cosine, then scale each axis
	function automatic xy_result_t transform_point(input logic signed [31:0] px,
			input logic signed [31:0] py);
		xy_result_t  res;
		bit          ovf;
		logic [15:0] biased;
		quadrant_t   quad;
		longint      tx, ty, cx, cy, nx, zacc, c, s, cs, sn, rx, ry;
		ovf = 1'b0;
		tx  = clamp32(longint'(px) + cfg_offset_x, ovf);
		ty  = clamp32(longint'(py) + cfg_offset_y, ovf);
		// fold the angle into a quadrant and a residue within one eighth of a turn
		biased = cfg_angle + ANGLE_BIAS;
		quad   = quadrant_t'(biased[15:14]);
		zacc   = (longint'(biased[13:0]) - longint'(ANGLE_BIAS)) * 65536;
		cx     = longint'(CORDIC_GAIN);
		cy     = 0;
		nx     = 0;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			if (zacc >= 0) begin
				nx   = cx - (cy >>> i);
				cy   = cy + (cx >>> i);
				zacc = zacc - longint'(ATAN_TURNS[i]);
			end else begin
				nx   = cx + (cy >>> i);
				cy   = cy - (cx >>> i);
				zacc = zacc + longint'(ATAN_TURNS[i]);
			end
			cx = nx;
		end
		c = (cx > UNIT_Q30) ? UNIT_Q30 : (cx < -UNIT_Q30) ? -UNIT_Q30 : cx;
		s = (cy > UNIT_Q30) ? UNIT_Q30 : (cy < -UNIT_Q30) ? -UNIT_Q30 : cy;
		case (quad)
			QUAD_0: begin
				cs = c;
				sn = s;
			end
			QUAD_90: begin
				cs = -s;
				sn = c;
			end
			QUAD_180: begin
				cs = -c;
				sn = -s;
			end
			default: begin
				cs = s;
				sn = -c;
			end
		endcase
		// both rotated coordinates take the translated x, not an updated one
		rx      = clamp32((tx * cs - ty * sn + HALF_Q30) >>> 30, ovf);
		ry      = clamp32((tx * sn + ty * cs + HALF_Q30) >>> 30, ovf);
		res.x   = 32'(clamp32((rx * cfg_scale_x + HALF_Q16) >>> 16, ovf));
		res.y   = 32'(clamp32((ry * cfg_scale_y + HALF_Q16) >>> 16, ovf));
		res.ovf = ovf;
		return res;
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return MAX_Q16;
			1: return MIN_Q16;
			2: return 32'h0;
			3, 4, 5, 6: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			7, 8: return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return SCALE_ONE;
			1: return MINUS_ONE;
			2: return 32'h0;
			3: return MAX_Q16;
			4: return MIN_Q16;
			5, 6, 7: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			default: return 32'($urandom);
		endcase
	endfunction

	// write one register over APB, then read it straight back
	task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] readback;
		logic [31:0] want_rb;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_OFFSET_X: cfg_offset_x = longint'($signed(value));
			REG_OFFSET_Y: cfg_offset_y = longint'($signed(value));
			REG_ROTATION: cfg_angle    = value[15:0];
			REG_SCALE_X:  cfg_scale_x  = longint'($signed(value));
			REG_SCALE_Y:  cfg_scale_y  = longint'($signed(value));
			default: ;
		endcase
		register_writes++;
		// keep psel high and turn the transfer into a read
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		want_rb = (idx == REG_ROTATION) ? {16'h0, value[15:0]} : value;
		if (readback !== want_rb)
			report_mismatch($sformatf("register %s read back %h, want %h",
				idx.name(), readback, want_rb));
		@(negedge clk);
	endtask

	// drop valid and hold until every outstanding result has been taken
	task automatic drain_pipeline();
		if (point_driven) begin
			pt_if.valid <= 1'b0;
			point_driven = 1'b0;
		end
		burst_left = 0;
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	// offer one point, in bursts with idle gaps between them
	task automatic send_point(input logic [31:0] px, input logic [31:0] py,
			input bit typed, input xy_result_t want);
		if (burst_left == 0) begin
			if (point_driven) begin
				pt_if.valid <= 1'b0;
				point_driven = 1'b0;
			end
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end
		pt_if.valid   <= 1'b1;
		pt_if.point_x <= px;
		pt_if.point_y <= py;
		point_driven = 1'b1;
		do @(posedge clk); while (!pt_if.ready);
		awaited_results.push_back(typed ? want : transform_point(px, py));
		points_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// receiver: long open stretches, short blips and longer stalls
	initial begin
		logic ready_level;
		int   ready_hold;
		ready_level = 1'b1;
		ready_hold  = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (ready_hold == 0) begin
				case ($urandom_range(0, 5))
					0, 1: begin
						ready_level = 1'b1;
						ready_hold  = $urandom_range(20, 200);
					end
					2, 3: begin
						ready_level = 1'b1;
						ready_hold  = $urandom_range(1, 6);
					end
					4: begin
						ready_level = 1'b0;
						ready_hold  = $urandom_range(1, 4);
					end
					default: begin
						ready_level = 1'b0;
						ready_hold  = $urandom_range(5, 30);
					end
				endcase
			end
			res_if.ready <= ready_level;
			ready_hold--;
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result (%0d, %0d) with nothing outstanding",
					res_if.result_x, res_if.result_y));
			end else begin
				head_result = awaited_results.pop_front();
				if (res_if.result_x !== head_result.x)
					report_mismatch($sformatf("result %0d: result_x %0d, want %0d",
						results_checked, res_if.result_x, head_result.x));
				if (res_if.result_y !== head_result.y)
					report_mismatch($sformatf("result %0d: result_y %0d, want %0d",
						results_checked, res_if.result_y, head_result.y));
				if (res_if.overflow !== head_result.ovf)
					report_mismatch($sformatf("result %0d: overflow %b, want %b",
						results_checked, res_if.overflow, head_result.ovf));
				if (head_result.ovf)
					overflow_seen++;
				results_checked++;
			end
		end
	end

	// stop a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Cycle limit of %0d reached with %0d results outstanding",
				CYCLE_LIMIT, awaited_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [15:0] angle;
		pt_if.valid   <= 1'b0;
		pt_if.point_x <= '0;
		pt_if.point_y <= '0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table: register writes only once the pipeline is empty
		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_WRITE) begin
				drain_pipeline();
				write_register(directed_rows[k].idx, directed_rows[k].a);
			end else begin
				send_point(directed_rows[k].a, directed_rows[k].b,
					directed_rows[k].typed, directed_rows[k].want);
			end
		end

		// random settings, each followed by a stream of random points
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_pipeline();
			write_register(REG_OFFSET_X, ($urandom_range(0, 2) == 0) ? 32'h0 : pick_coord());
			write_register(REG_OFFSET_Y, ($urandom_range(0, 2) == 0) ? 32'h0 : pick_coord());
			case ($urandom_range(0, 3))
				0: angle = 16'($urandom_range(0, 7)) << 13;
				// either side of an octant boundary
				1: angle = (16'($urandom_range(0, 7)) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
				default: angle = 16'($urandom);
			endcase
			write_register(REG_ROTATION, {16'h0, angle});
			write_register(REG_SCALE_X, pick_scale());
			write_register(REG_SCALE_Y, pick_scale());
			repeat (POINTS_PER_PHASE)
				send_point(pick_coord(), pick_coord(), 1'b0, NO_RESULT);
		end

		drain_pipeline();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d points under %0d register writes; checked %0d results, %0d saturated",
			points_sent, register_writes, results_checked, overflow_seen);
		$display("Mismatches found: %0d", mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
